FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define DLRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define DLRS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/dlrs_pkg.sv
// Shared constants and sizing functions for the decimal radix sorter.
package dlrs_pkg;

  localparam int RADIX = 10;
  localparam int DIGIT_BITS = 4;

  // Number of decimal digits needed for the largest value of the given width.
  function automatic int dec_digits(input int bits);
    return (bits * 30103) / 100000 + 1;
  endfunction

endpackage

FILE: sv/dlrs_front.sv
// Front end: accepts keys and converts each one to packed decimal digits.
module dlrs_front #(
  parameter int KEY_BITS = 32,
  parameter int NDIG     = 10,
  parameter int DW       = 4,
  parameter int IW       = 1 + 4 + 40 + 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [31:0]   key,
  input  logic          final_key,
  input  logic          in_valid,
  output logic          in_ready,
  output logic [IW-1:0] item_data,
  output logic          item_valid,
  input  logic          item_ready
);

  localparam int BW  = NDIG * dlrs_pkg::DIGIT_BITS;
  localparam int CNW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CONV = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]          state;
  logic [KEY_BITS-1:0] kreg;
  logic [KEY_BITS-1:0] sh;
  logic [BW-1:0]       bcd;
  logic [BW-1:0]       adj;
  logic [BW-1:0]       bcd_next;
  logic                last;
  logic [CNW-1:0]      cnt;
  logic [DW-1:0]       nd;

  // Add three to every digit of five or more, then shift in the next key bit.
  always_comb begin
    for (int g = 0; g < NDIG; g++) begin
      adj[g*4 +: 4] = (bcd[g*4 +: 4] >= 4'd5) ? bcd[g*4 +: 4] + 4'd3 : bcd[g*4 +: 4];
    end
    bcd_next = {adj[BW-2:0], sh[KEY_BITS-1]};
  end

  // Count of significant decimal digits.
  always_comb begin
    nd = '0;
    for (int g = 0; g < NDIG; g++) begin
      if (bcd[g*4 +: 4] != 4'd0) nd = DW'(g + 1);
    end
  end

  assign in_ready   = (state == F_IDLE);
  assign item_valid = (state == F_PUSH);
  assign item_data  = {last, nd, bcd, kreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            kreg  <= KEY_BITS'(key);
            sh    <= KEY_BITS'(key);
            bcd   <= '0;
            last  <= final_key;
            cnt   <= '0;
            state <= F_CONV;
          end
        end
        F_CONV: begin
          bcd <= bcd_next;
          sh  <= sh << 1;
          cnt <= cnt + 1'b1;
          if (cnt == CNW'(KEY_BITS - 1)) state <= F_PUSH;
        end
        F_PUSH: begin
          if (item_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/dlrs_fifo.sv
// Two-entry queue between the front end and the sort engine.
module dlrs_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [W-1:0] wr_data,
  input  logic         wr_valid,
  output logic         wr_ready,
  output logic [W-1:0] rd_data,
  output logic         rd_valid,
  input  logic         rd_ready
);

  logic [W-1:0] mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   fill;
  logic         push;
  logic         pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data  = mem[rp];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: sv/dlrs_back.sv
// Sort engine: stores keys, runs the decimal radix passes and emits the result.
module dlrs_back #(
  parameter int MAX_KEYS    = 64,
  parameter int KEY_BITS    = 32,
  parameter int NUM_BUCKETS = 10,
  parameter int NDIG        = 10,
  parameter int DW          = 4,
  parameter int IW          = 1 + 4 + 40 + 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [IW-1:0] item_data,
  input  logic          item_valid,
  output logic          item_ready,
  output logic [31:0]   sorted_key,
  output logic          end_of_set,
  output logic          out_valid,
  input  logic          out_ready
);

  localparam int BW  = NDIG * dlrs_pkg::DIGIT_BITS;
  localparam int WW  = KEY_BITS + BW;
  localparam int CW  = $clog2(MAX_KEYS + 1);
  localparam int AW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int BKW = $clog2(NUM_BUCKETS);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_CNT  = 3'd1;
  localparam logic [2:0] S_PFX  = 3'd2;
  localparam logic [2:0] S_SCT  = 3'd3;
  localparam logic [2:0] S_ERD  = 3'd4;
  localparam logic [2:0] S_EWT  = 3'd5;
  localparam logic [2:0] S_EHD  = 3'd6;

  logic [WW-1:0] bank0 [MAX_KEYS];
  logic [WW-1:0] bank1 [MAX_KEYS];
  logic [WW-1:0] rd0;
  logic [WW-1:0] rd1;

  logic [CW-1:0] counts [NUM_BUCKETS];
  logic [CW-1:0] acc;
  logic [CW-1:0] sum;

  logic [2:0]     state;
  logic           sel;
  logic [CW-1:0]  n;
  logic [DW-1:0]  maxdig;
  logic [DW-1:0]  maxdig_next;
  logic [DW-1:0]  pass;
  logic [CW-1:0]  idx;
  logic [CW-1:0]  idx_m1;
  logic           rd_v;
  logic [BKW-1:0] pfx_j;

  logic [KEY_BITS-1:0] it_key;
  logic [BW-1:0]       it_bcd;
  logic [DW-1:0]       it_nd;
  logic                it_last;
  logic                load;
  logic                store;

  logic [AW-1:0]       raddr;
  logic [WW-1:0]       rword;
  logic [KEY_BITS-1:0] r_key;
  logic [BW-1:0]       r_bcd;
  logic [BKW-1:0]      r_dig;
  logic [CW-1:0]       pos;
  logic                sct_wr;
  logic                sct_done;
  logic                we0;
  logic                we1;
  logic [AW-1:0]       waddr;
  logic [WW-1:0]       wdata;

  assign it_key  = item_data[KEY_BITS-1:0];
  assign it_bcd  = item_data[KEY_BITS +: BW];
  assign it_nd   = item_data[KEY_BITS+BW +: DW];
  assign it_last = item_data[IW-1];

  assign item_ready  = (state == S_LOAD);
  assign load        = item_valid && item_ready;
  assign store       = load && (n != CW'(MAX_KEYS));
  assign maxdig_next = (store && (it_nd > maxdig)) ? it_nd : maxdig;

  assign idx_m1 = idx - 1'b1;

  always_comb begin
    case (state)
      S_CNT:   raddr = idx[AW-1:0];
      S_ERD:   raddr = idx[AW-1:0];
      S_SCT:   raddr = idx_m1[AW-1:0];
      default: raddr = '0;
    endcase
  end

  assign rword = sel ? rd1 : rd0;
  assign r_key = rword[KEY_BITS-1:0];
  assign r_bcd = rword[KEY_BITS +: BW];
  assign r_dig = BKW'(r_bcd[{pass, 2'b00} +: 4]);
  assign pos   = counts[r_dig] - 1'b1;
  assign sum   = acc + counts[0];

  assign sct_wr   = (state == S_SCT) && rd_v;
  assign sct_done = (state == S_SCT) && (idx == '0) && !rd_v;

  // Loads go to the source bank, scatter writes to the other one.
  assign we0   = (store && !sel) || (sct_wr && sel);
  assign we1   = (store && sel) || (sct_wr && !sel);
  assign waddr = store ? n[AW-1:0] : pos[AW-1:0];
  assign wdata = store ? {it_bcd, it_key} : rword;

  always_ff @(posedge clk) begin
    if (we0) bank0[waddr] <= wdata;
    rd0 <= bank0[raddr];
  end

  always_ff @(posedge clk) begin
    if (we1) bank1[waddr] <= wdata;
    rd1 <= bank1[raddr];
  end

  // Bucket counters: histogram, rotating prefix sum, then scatter positions.
  always_ff @(posedge clk) begin
    if ((state == S_LOAD) || sct_done) begin
      for (int b = 0; b < NUM_BUCKETS; b++) counts[b] <= '0;
    end else if ((state == S_CNT) && rd_v) begin
      counts[r_dig] <= counts[r_dig] + 1'b1;
    end else if (state == S_PFX) begin
      for (int b = 0; b < NUM_BUCKETS - 1; b++) counts[b] <= counts[b+1];
      counts[NUM_BUCKETS-1] <= sum;
    end else if (sct_wr) begin
      counts[r_dig] <= pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      sel       <= 1'b0;
      n         <= '0;
      maxdig    <= '0;
      pass      <= '0;
      idx       <= '0;
      rd_v      <= 1'b0;
      pfx_j     <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (load) begin
            if (store) n <= n + 1'b1;
            maxdig <= maxdig_next;
            if (it_last) begin
              pass  <= '0;
              idx   <= '0;
              rd_v  <= 1'b0;
              state <= (maxdig_next == '0) ? S_ERD : S_CNT;
            end
          end
        end
        S_CNT: begin
          if (idx != n) begin
            idx  <= idx + 1'b1;
            rd_v <= 1'b1;
          end else begin
            rd_v <= 1'b0;
            if (!rd_v) begin
              pfx_j <= '0;
              acc   <= '0;
              state <= S_PFX;
            end
          end
        end
        S_PFX: begin
          acc   <= sum;
          pfx_j <= pfx_j + 1'b1;
          if (pfx_j == BKW'(NUM_BUCKETS - 1)) begin
            idx   <= n;
            state <= S_SCT;
          end
        end
        S_SCT: begin
          if (idx != '0) begin
            idx  <= idx_m1;
            rd_v <= 1'b1;
          end else begin
            rd_v <= 1'b0;
            if (!rd_v) begin
              sel   <= ~sel;
              pass  <= pass + 1'b1;
              idx   <= '0;
              state <= ((pass + 1'b1) == maxdig) ? S_ERD : S_CNT;
            end
          end
        end
        S_ERD: begin
          state <= S_EWT;
        end
        S_EWT: begin
          sorted_key <= 32'(r_key);
          end_of_set <= ((idx + 1'b1) == n);
          out_valid  <= 1'b1;
          state      <= S_EHD;
        end
        S_EHD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (end_of_set) begin
              n      <= '0;
              maxdig <= '0;
              state  <= S_LOAD;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_ERD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

FILE: sv/decimal_lsd_radix_sorter_core.sv
// Flow: the front end forms each key's decimal digits, one key bit per cycle. A set of keys
// whose largest key has d decimal digits sorts in d passes (count, prefix sum, scatter), and
// the sorted keys are then emitted one at a time through the output handshake.
// The front end takes a new key only once it is done with the last one, and the two-entry
// queue holds up to two converted keys of the next set while the engine sorts or emits.
// Reset: synchronous, active high; the set is emptied and both handshakes go idle.
module decimal_lsd_radix_sorter_core #(
  parameter int MAX_KEYS    = 64,
  parameter int KEY_BITS    = 32,
  parameter int NUM_BUCKETS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] key,
  input  logic        final_key,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [31:0] sorted_key,
  output logic        end_of_set,
  output logic        out_valid,
  input  logic        out_ready
);

  // Digit count of the widest key and the width of one queued request.
  localparam int NDIG = dlrs_pkg::dec_digits(KEY_BITS);
  localparam int DW   = $clog2(NDIG + 1);
  localparam int IW   = 1 + DW + NDIG * dlrs_pkg::DIGIT_BITS + KEY_BITS;

  logic [IW-1:0] f_data;
  logic          f_valid;
  logic          f_ready;
  logic [IW-1:0] q_data;
  logic          q_valid;
  logic          q_ready;

  // The front end converts each request to packed decimal and tags its digit count.
  dlrs_front #(
    .KEY_BITS (KEY_BITS),
    .NDIG     (NDIG),
    .DW       (DW),
    .IW       (IW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .key        (key),
    .final_key  (final_key),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item_data  (f_data),
    .item_valid (f_valid),
    .item_ready (f_ready)
  );

  // The queue lets the front end keep converting while the engine sorts or emits.
  dlrs_fifo #(
    .W (IW)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (f_data),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_data  (q_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  // The engine ping-pongs between two banks, one pass per significant digit.
  dlrs_back #(
    .MAX_KEYS    (MAX_KEYS),
    .KEY_BITS    (KEY_BITS),
    .NUM_BUCKETS (NUM_BUCKETS),
    .NDIG        (NDIG),
    .DW          (DW),
    .IW          (IW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_data  (q_data),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .sorted_key (sorted_key),
    .end_of_set (end_of_set),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule

FILE: sv/dlrs_checker.sv
// Port-level checker for the radix sorter, bound to the top level.
`include "assert_macros.svh"

module dlrs_checker #(
  parameter int MAX_KEYS = 64,
  parameter int KEY_BITS = 32
) (
  input logic        clk,
  input logic        rst,
  input logic [31:0] sorted_key,
  input logic        end_of_set,
  input logic        out_valid,
  input logic        out_ready
);

  localparam int CW = $clog2(MAX_KEYS + 1);

  logic          out_acc;
  logic          in_set;
  logic [31:0]   prev_key;
  logic [CW-1:0] out_cnt;

  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_set  <= 1'b0;
      out_cnt <= '0;
    end else if (out_acc) begin
      in_set   <= !end_of_set;
      prev_key <= sorted_key;
      out_cnt  <= end_of_set ? '0 : out_cnt + 1'b1;
    end
  end

  `DLRS_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(sorted_key) && $stable(end_of_set))
  `DLRS_ASSERT_NOW(a_ascending, out_acc && in_set && (KEY_BITS <= 32), sorted_key >= prev_key)
  `DLRS_ASSERT_NOW(a_set_size, out_acc, out_cnt < CW'(MAX_KEYS))
  `DLRS_ASSERT_NOW(a_reset_quiet, $past(rst), !out_valid)

endmodule

bind decimal_lsd_radix_sorter_core dlrs_checker #(
  .MAX_KEYS (MAX_KEYS),
  .KEY_BITS (KEY_BITS)
) u_dlrs_checker (.*);
